// ===== hw/rtl/tpcs_pkg.sv =====
// tpcs_pkg: shared types, constants and tables for the timer prescale block
// used by the channel interfaces, the divider and the top level
package tpcs_pkg;

	localparam int FreqW  = 31;
	localparam int LimitW = 16;
	localparam int CodeW  = 3;
	localparam int DivW   = 32;
	localparam int DivCntW = $clog2(DivW);
	localparam int ShiftW = 4;
	localparam int NumTrials = 5;
	localparam int TrialW = $clog2(NumTrials);

	localparam logic [DivW-1:0] ClockHzReset = 32'd16000000;
	localparam logic [TrialW-1:0] LastTrial = TrialW'(NumTrials - 1);
	localparam logic [CodeW-1:0] CodeDiv1024 = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_TRIAL,
		ST_DONE
	} tpcs_state_t;

	typedef struct packed {
		logic start;
	} tpcs_div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tpcs_div_sts_t;

	// prescaler shift of each trial: /1, /8, /64, /256, /1024
	function automatic logic [ShiftW-1:0] trial_shift(input logic [TrialW-1:0] idx);
		logic [ShiftW-1:0] sh;
		case (idx)
			3'd0:    sh = 4'd0;
			3'd1:    sh = 4'h3;
			3'd2:    sh = 4'h6;
			3'd3:    sh = 4'h8;
			3'd4:    sh = 4'ha;
			default: sh = 4'ha;
		endcase
		return sh;
	endfunction

	// clock-select code of each trial
	function automatic logic [CodeW-1:0] trial_code(input logic [TrialW-1:0] idx);
		return CodeW'(idx) + CodeW'(1);
	endfunction

endpackage

// ===== hw/rtl/tpcs_if.sv =====
// tpcs_in_if / tpcs_out_if: valid-ready channels of the timer prescale block
// depends on tpcs_pkg for field widths
interface tpcs_in_if;
	import tpcs_pkg::*;
	logic              valid;
	logic              ready;
	logic [FreqW-1:0]  target_freq;
	logic [LimitW-1:0] compare_limit;

	modport source (output valid, output target_freq, output compare_limit, input ready);
	modport sink (input valid, input target_freq, input compare_limit, output ready);
endinterface

interface tpcs_out_if;
	import tpcs_pkg::*;
	logic              valid;
	logic              ready;
	logic [LimitW-1:0] compare_value;
	logic [CodeW-1:0]  clock_select;

	modport source (output valid, output compare_value, output clock_select, input ready);
	modport sink (input valid, input compare_value, input clock_select, output ready);
endinterface

// ===== hw/rtl/timer_prescale_compare_select.sv =====
// Picks a timer prescaler and compare value for a wanted toggle frequency.
// One word passes from acceptance to result through the bit-serial divider that
// forms clock_hz / (2 * target_freq), a hand-over of the quotient, then the
// prescaler trials in order (up to five) in the shared shift-and-compare unit,
// since clock_hz / ((2*f) << s) equals that quotient shifted right by s, and the
// result is then offered on out_ch until taken. A zero frequency skips the divider
// and the trials and goes straight to the result. One word is
// in flight at a time; in_ch.ready is low from acceptance until the result is
// taken. clock_hz is written through cfg_wr_en/cfg_wr_data and resets to 16 MHz.
// depends on tpcs_pkg, tpcs_if (channels) and tpcs_div
module timer_prescale_compare_select (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [tpcs_pkg::DivW-1:0] cfg_wr_data,
	tpcs_in_if.sink                   in_ch,
	tpcs_out_if.source                out_ch
);
	import tpcs_pkg::*;

	tpcs_state_t state_q, state_d;

	logic [DivW-1:0]   clock_hz_q;
	logic [LimitW-1:0] limit_q;
	logic [TrialW-1:0] trial_q;
	logic [LimitW-1:0] cv_q;
	logic [CodeW-1:0]  cs_q;

	tpcs_div_ctl_t   div_ctl;
	tpcs_div_sts_t   div_sts;
	logic [DivW-1:0] div_quo;

	logic            in_ready;
	logic            out_valid;
	logic            accept;
	logic            zero_freq;
	logic [DivW-1:0] q_sh;
	logic            fits;
	logic            trial_end;

	assign accept    = in_ch.valid & in_ready;
	assign zero_freq = (in_ch.target_freq == '0);

	// shared shift and compare unit
	assign q_sh      = div_quo >> trial_shift(trial_q);
	assign fits      = (q_sh <= {{(DivW-LimitW){1'b0}}, limit_q});
	assign trial_end = fits | (trial_q == LastTrial);

	tpcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (clock_hz_q),
		.divisor  ({in_ch.target_freq, 1'b0}),
		.sts      (div_sts),
		.quotient (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = zero_freq ? ST_DONE : ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_sts.done) begin
					state_d = ST_TRIAL;
				end
			end
			ST_TRIAL: begin
				if (trial_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_ch.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		div_ctl.start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				div_ctl.start = in_ch.valid & ~zero_freq;
			end
			ST_DONE: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			clock_hz_q <= ClockHzReset;
			trial_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				clock_hz_q <= cfg_wr_data;
			end
			if (accept) begin
				trial_q <= '0;
			end else if (state_q == ST_TRIAL && !trial_end) begin
				trial_q <= trial_q + TrialW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			limit_q <= in_ch.compare_limit;
			if (zero_freq) begin
				cv_q <= in_ch.compare_limit;
				cs_q <= CodeDiv1024;
			end
		end else if (state_q == ST_TRIAL && trial_end) begin
			cv_q <= fits ? q_sh[LimitW-1:0] : limit_q;
			cs_q <= trial_code(trial_q);
		end
	end

	assign in_ch.ready          = in_ready;
	assign out_ch.valid         = out_valid;
	assign out_ch.compare_value = cv_q;
	assign out_ch.clock_select  = cs_q;

endmodule

// ===== hw/rtl/tpcs_div.sv =====
// tpcs_div: radix-2 restoring divider, one quotient bit per cycle
// depends on tpcs_pkg for widths and the control/status structs
module tpcs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tpcs_pkg::tpcs_div_ctl_t       ctl,
	input  logic [tpcs_pkg::DivW-1:0]     dividend,
	input  logic [tpcs_pkg::DivW-1:0]     divisor,
	output tpcs_pkg::tpcs_div_sts_t       sts,
	output logic [tpcs_pkg::DivW-1:0]     quotient
);
	import tpcs_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [DivCntW-1:0] cnt_q;
	logic [DivW-1:0]    rem_q;
	logic [DivW-1:0]    quo_q;
	logic [DivW-1:0]    dsr_q;

	logic [DivW:0]   rem_shift;
	logic [DivW+1:0] diff;
	logic            ge;

	assign rem_shift = {rem_q, quo_q[DivW-1]};
	assign diff      = {1'b0, rem_shift} - {2'b00, dsr_q};
	assign ge        = ~diff[DivW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivCntW'(DivW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DivCntW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DivW-1:0] : rem_shift[DivW-1:0];
			quo_q <= {quo_q[DivW-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule

// ===== sim/testbench.sv =====
// testbench for timer_prescale_compare_select: drives target_freq/compare_limit words
// under several clock_hz settings and checks each result against an in-bench predictor
// depends on tpcs_pkg, tpcs_in_if/tpcs_out_if and the timer_prescale_compare_select rtl
module testbench;
	import tpcs_pkg::*;

	localparam int CycleLimit = 500000;
	localparam int DrainCycles = 50;

	typedef enum logic [CodeW-1:0] {
		SEL_DIV1 = 3'd1,
		SEL_DIV8 = 3'd2,
		SEL_DIV64 = 3'd3,
		SEL_DIV256 = 3'd4,
		SEL_DIV1024 = 3'd5
	} prescale_sel_t;

	typedef enum int {
		RX_STEADY,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	typedef struct packed {
		logic [FreqW-1:0]  target_freq;
		logic [LimitW-1:0] compare_limit;
	} timer_request_t;

	typedef struct packed {
		logic [LimitW-1:0] compare_value;
		logic [CodeW-1:0]  clock_select;
	} timer_setting_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en;
	logic [DivW-1:0] cfg_wr_data;

	tpcs_in_if req_ch();
	tpcs_out_if rsp_ch();

	timer_prescale_compare_select dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch(req_ch),
		.out_ch(rsp_ch)
	);

	timer_request_t pending_requests[$];
	timer_setting_t expected_settings[$];
	logic [DivW-1:0] clock_hz_model = ClockHzReset;
	logic in_taken = 1'b0;
	int queued_words = 0;
	int checked_words = 0;
	int error_count = 0;
	int cycle_count = 0;
	int clock_settings = 1;
	int code_hits [8];
	int burst_left = 1;
	int gap_left = 0;
	rx_mode_t rx_mode = RX_STEADY;
	int rx_left = 0;
	logic [7:0] rx_pattern = 8'hff;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic timer_setting_t select_prescaler(input logic [FreqW-1:0] freq,
			input logic [LimitW-1:0] limit, input logic [DivW-1:0] clk_hz);
		timer_setting_t res;
		logic [63:0] quotient;
		logic [63:0] divisor;
		logic [CodeW-1:0] code;
		int shift;
		logic fits;
		fits = 1'b0;
		quotient = '0;
		code = SEL_DIV1;
		for (int t = 0; t < NumTrials; t++) begin
			if (!fits) begin
				case (t)
					0: begin
						shift = 0;
						code = SEL_DIV1;
					end
					1: begin
						shift = 3;
						code = SEL_DIV8;
					end
					2: begin
						shift = 6;
						code = SEL_DIV64;
					end
					3: begin
						shift = 8;
						code = SEL_DIV256;
					end
					default: begin
						shift = 10;
						code = SEL_DIV1024;
					end
				endcase
				if (freq != '0) begin
					divisor = {32'b0, freq, 1'b0} << shift;
					quotient = {32'b0, clk_hz} / divisor;
					fits = (quotient <= {48'b0, limit});
				end
			end
		end
		res.compare_value = fits ? quotient[LimitW-1:0] : limit;
		res.clock_select = code;
		return res;
	endfunction

	task automatic queue_request(input logic [FreqW-1:0] freq, input logic [LimitW-1:0] limit);
		timer_request_t req;
		req.target_freq = freq;
		req.compare_limit = limit;
		pending_requests.push_back(req);
		queued_words++;
	endtask

	task automatic queue_random(input int count);
		logic [FreqW-1:0] freq;
		logic [LimitW-1:0] limit;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 5)
				freq = '0;
			else if (pick < 40)
				freq = FreqW'($urandom_range(2000, 1));
			else if (pick < 70)
				freq = FreqW'($urandom_range(1 << 20, 1));
			else
				freq = FreqW'($urandom);
			pick = $urandom_range(99);
			if (pick < 25)
				limit = 16'd255;
			else if (pick < 50)
				limit = 16'hffff;
			else if (pick < 58)
				limit = '0;
			else
				limit = LimitW'($urandom);
			queue_request(freq, limit);
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (checked_words != queued_words);
	endtask

	task automatic write_clock(input logic [DivW-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		clock_settings++;
	endtask

	// sender: bursts of words separated by random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!(req_ch.valid && !in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				req_ch.valid <= 1'b1;
				req_ch.target_freq <= pending_requests[0].target_freq;
				req_ch.compare_limit <= pending_requests[0].compare_limit;
				void'(pending_requests.pop_front());
				if (burst_left <= 1) begin
					burst_left = $urandom_range(10, 1);
					gap_left = ($urandom_range(99) < 30) ? 0 : $urandom_range(12, 1);
				end else begin
					burst_left--;
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: steady, random and pattern stall modes, switched at random
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(2));
				rx_left = $urandom_range(80, 10);
				rx_pattern = 8'($urandom) | 8'h01;
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_STEADY: rsp_ch.ready <= 1'b1;
				RX_RANDOM: rsp_ch.ready <= ($urandom_range(99) >= 40);
				default: begin
					rsp_ch.ready <= rx_pattern[0];
					rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
				end
			endcase
		end
	end

	always @(posedge clk) begin
		timer_setting_t want;
		in_taken <= req_ch.valid && req_ch.ready;
		if (arst_n) begin
			if (cfg_wr_en)
				clock_hz_model = cfg_wr_data;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_settings.size() == 0) begin
					$error("unexpected word: compare_value %0d clock_select %0d",
						rsp_ch.compare_value, rsp_ch.clock_select);
					error_count++;
				end else begin
					want = expected_settings.pop_front();
					if (rsp_ch.compare_value !== want.compare_value) begin
						$error("compare_value: expected %0d, got %0d",
							want.compare_value, rsp_ch.compare_value);
						error_count++;
					end
					if (rsp_ch.clock_select !== want.clock_select) begin
						$error("clock_select: expected %0d, got %0d",
							want.clock_select, rsp_ch.clock_select);
						error_count++;
					end
					code_hits[want.clock_select]++;
					checked_words <= checked_words + 1;
				end
			end
			if (req_ch.valid && req_ch.ready)
				expected_settings.push_back(select_prescaler(req_ch.target_freq,
					req_ch.compare_limit, clock_hz_model));
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CycleLimit) begin
			$display("timer_prescale_compare_select test failed");
			$finish;
		end
	end

	initial begin
		logic [DivW-1:0] clock_value;
		req_ch.valid = 1'b0;
		req_ch.target_freq = '0;
		req_ch.compare_limit = '0;
		rsp_ch.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset clock of 16 MHz
		queue_request('0, 16'd0);
		queue_request('0, 16'hffff);
		queue_request('0, 16'd255);
		queue_request(31'h7fffffff, 16'd0);
		queue_request(31'h7fffffff, 16'hffff);
		queue_request(31'd1, 16'hffff);
		queue_request(31'd1, 16'd255);
		queue_request(31'd1, 16'd0);
		queue_request(31'd8000000, 16'd255);
		queue_request(31'd40000, 16'd255);
		queue_request(31'd4000, 16'd255);
		queue_request(31'd500, 16'd255);
		queue_request(31'd125, 16'd255);
		queue_request(31'd40, 16'd255);
		// quotient above 16 bits whose low bits alone would fit
		queue_request(31'd122, 16'd100);
		queue_request(31'd30, 16'hffff);
		queue_request(31'd16000000, 16'd1);
		queue_request(31'h55555555, 16'haaaa);
		queue_request(31'h2aaaaaaa, 16'h5555);
		queue_random(36);
		wait_drained();
		@(posedge clk);
		queue_random(36);

		for (int phase = 0; phase < 5; phase++) begin
			wait_drained();
			repeat (3) @(negedge clk);
			case (phase)
				0: clock_value = '0;
				1: clock_value = 32'hffffffff;
				2: clock_value = 32'd1;
				3: clock_value = 32'($urandom);
				default: clock_value = 32'd20000000;
			endcase
			write_clock(clock_value);
			@(posedge clk);
			queue_request('0, LimitW'($urandom));
			queue_request(31'd1, 16'hffff);
			queue_request(31'h7fffffff, 16'd0);
			queue_random(36);
			wait_drained();
			@(posedge clk);
			queue_random(36);
		end

		wait_drained();
		repeat (DrainCycles) @(negedge clk);
		if (expected_settings.size() != 0) begin
			$error("%0d results never arrived", expected_settings.size());
			error_count++;
		end
		$display("%0d words checked across %0d clock_hz values, %0d errors",
			checked_words, clock_settings, error_count);
		$display("results by prescaler /1 %0d, /8 %0d, /64 %0d, /256 %0d, /1024 %0d",
			code_hits[SEL_DIV1], code_hits[SEL_DIV8], code_hits[SEL_DIV64],
			code_hits[SEL_DIV256], code_hits[SEL_DIV1024]);
		if (error_count == 0)
			$display("timer_prescale_compare_select test passed");
		else
			$display("timer_prescale_compare_select test failed");
		$finish;
	end

endmodule

// ===== timer_prescale_compare_select.f =====
hw/rtl/tpcs_pkg.sv
hw/rtl/tpcs_if.sv
hw/rtl/tpcs_div.sv
hw/rtl/timer_prescale_compare_select.sv
sim/testbench.sv
